// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the alarm table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AR(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_CK(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_AR(label, clk, rst_n, prop)
`define ASSERT_CK(label, clk, prop)
`endif
`endif

// ----- hdl/ate_pkg.sv -----
// Types, sizes and codes shared by the alarm table modules.
package ate_pkg;
	localparam int ENTRIES     = 16;
	localparam int MS_PER_TICK = 10;
	localparam int MAX_RESULTS = 16;

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int FIRE_W = $clog2(MAX_RESULTS + 1);
	localparam int DIV_W  = 10;

	localparam logic [IDX_W:0] ENT_SUM = (IDX_W + 1)'(ENTRIES);
	localparam logic [CNT_W-1:0] ENT_CNT = CNT_W'(ENTRIES);
	localparam logic [FIRE_W-1:0] MAX_FIRE = FIRE_W'(MAX_RESULTS);

	// Reciprocal of the tick length, scaled by 2^32.
	localparam logic [32:0] RECIP = 33'((64'd1 << 32) / MS_PER_TICK);
	localparam logic [DIV_W-1:0] DIVISOR = DIV_W'(MS_PER_TICK);

	localparam logic CMD_REG  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [1:0] KIND_REG   = 2'd0;
	localparam logic [1:0] KIND_FULL  = 2'd1;
	localparam logic [1:0] KIND_FIRED = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	typedef struct packed {
		logic              cmd;
		logic [15:0]       process_id;
		logic signed [7:0] alert_tag;
		logic [31:0]       delay_ms;
	} in_word_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [15:0]       alert_pid;
		logic signed [7:0] alert_prefix;
		logic              last;
	} out_word_t;

	typedef struct packed {
		logic [15:0]       pid;
		logic signed [7:0] prefix;
		logic [63:0]       deadline;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);
endpackage

// ----- hdl/ate_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ate_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hdl/ate_div.sv -----
// Divides the delay by the tick length through a reciprocal multiply and one correction.
`include "assert_macros.svh"
module ate_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	output logic        valid,
	output logic [31:0] quotient
);
	logic        vld_s1;
	logic [31:0] x_s1;
	logic [64:0] prod_s1;
	logic [31:0] est;
	logic [41:0] qd;
	logic [41:0] rem;

	// The estimate never exceeds the true quotient and is at most one below it.
	assign est = prod_s1[63:32];
	assign qd  = {10'd0, est} * {32'd0, ate_pkg::DIVISOR};
	assign rem = {10'd0, x_s1} - qd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			valid  <= 1'b0;
		end else begin
			vld_s1 <= start;
			valid  <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_s1    <= dividend;
			prod_s1 <= {33'd0, dividend} * {32'd0, ate_pkg::RECIP};
		end
		if (vld_s1) begin
			quotient <= est + 32'(rem >= 42'(ate_pkg::MS_PER_TICK));
		end
	end

	`ASSERT_AR(a_est_close, clk, arst_n, vld_s1 |-> (rem < 42'(2 * ate_pkg::MS_PER_TICK)))
endmodule

// ----- hdl/alarm_table_expiry.sv -----
// Top level of the alarm table: command sequencer around the entry memory.
//
//  channel   ports                    direction  handshake
//  item      start, busy, item        in         taken when start is high and busy is low
//  result    strobe, result           out        one word per strobe cycle, never held off
//
// A register word keeps busy high through the reciprocal divider and answers as busy falls.
// A rejected register word answers in the cycle after it is taken and leaves busy low.
// A tick word keeps busy high while it reads each entry, waits for the read data and closes
// the scan; alerts stream out during the scan and the final one closes it.
// Reset clears the tick counter, the entry count and the result strobe; memory is not cleared.
// Results leave through a register, so the next word can be taken while one is shown.
`include "assert_macros.svh"
module alarm_table_expiry (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ate_pkg::in_word_t  item,
	output logic               strobe,
	output ate_pkg::out_word_t result
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;

	logic [1:0]                     state_q;
	logic [63:0]                    tick_q;
	logic [ate_pkg::CNT_W-1:0]      count_q;
	logic [ate_pkg::IDX_W-1:0]      head_q;
	logic [ate_pkg::CNT_W-1:0]      rd_q;
	logic [ate_pkg::CNT_W-1:0]      wr_q;
	logic [ate_pkg::FIRE_W-1:0]     fired_q;
	logic                           vld_s1;
	logic                           pend_q;
	logic [15:0]                    pend_pid_q;
	logic signed [7:0]              pend_prefix_q;
	logic [15:0]                    pid_q;
	logic signed [7:0]              tag_q;

	logic                           accept;
	logic                           div_valid;
	logic [31:0]                    div_quot;
	logic                           issue;
	logic                           hit;
	logic [ate_pkg::IDX_W-1:0]      head_dec;
	logic                           we;
	logic [ate_pkg::IDX_W-1:0]      waddr;
	ate_pkg::entry_t                wdata;
	logic [ate_pkg::IDX_W-1:0]      raddr;
	ate_pkg::entry_t                rdata;

	function automatic logic [ate_pkg::IDX_W-1:0] phys(
		input logic [ate_pkg::IDX_W-1:0] base,
		input logic [ate_pkg::IDX_W-1:0] off
	);
		logic [ate_pkg::IDX_W:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= ate_pkg::ENT_SUM) begin
			sum = sum - ate_pkg::ENT_SUM;
		end
		return sum[ate_pkg::IDX_W-1:0];
	endfunction

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign issue    = (state_q == ST_SCAN) && (rd_q < count_q);
	assign hit      = (fired_q < ate_pkg::MAX_FIRE) && (rdata.deadline <= tick_q);
	assign head_dec = (head_q == '0) ? ate_pkg::IDX_W'(ate_pkg::ENTRIES - 1)
	                                 : head_q - ate_pkg::IDX_W'(1);
	assign raddr    = phys(head_q, rd_q[ate_pkg::IDX_W-1:0]);

	// Entry 0 of the table sits at head_q; survivors of a tick are packed back from there.
	always_comb begin
		we    = 1'b0;
		waddr = head_dec;
		wdata = rdata;
		if (state_q == ST_DIV && div_valid) begin
			we             = 1'b1;
			wdata.pid      = pid_q;
			wdata.prefix   = tag_q;
			wdata.deadline = {32'd0, div_quot} + tick_q;
		end else if (state_q == ST_SCAN && vld_s1 && !hit) begin
			we    = 1'b1;
			waddr = phys(head_q, wr_q[ate_pkg::IDX_W-1:0]);
		end
	end

	ate_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && item.cmd == ate_pkg::CMD_REG && count_q != ate_pkg::ENT_CNT),
		.dividend (item.delay_ms),
		.valid    (div_valid),
		.quotient (div_quot)
	);

	ate_ram #(
		.WIDTH (ate_pkg::ENTRY_W),
		.DEPTH (ate_pkg::ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tick_q  <= '0;
			count_q <= '0;
			head_q  <= '0;
			rd_q    <= '0;
			wr_q    <= '0;
			fired_q <= '0;
			vld_s1  <= 1'b0;
			pend_q  <= 1'b0;
			strobe  <= 1'b0;
		end else begin
			strobe <= 1'b0;
			vld_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.cmd == ate_pkg::CMD_TICK) begin
							tick_q  <= tick_q + 64'd1;
							rd_q    <= '0;
							wr_q    <= '0;
							fired_q <= '0;
							pend_q  <= 1'b0;
							state_q <= ST_SCAN;
						end else if (count_q == ate_pkg::ENT_CNT) begin
							strobe <= 1'b1;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_valid) begin
						head_q  <= head_dec;
						count_q <= count_q + ate_pkg::CNT_W'(1);
						strobe  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_q <= rd_q + ate_pkg::CNT_W'(1);
					end
					if (vld_s1) begin
						if (hit) begin
							// A fired word is held back one step so that the final one can carry last.
							strobe  <= pend_q;
							pend_q  <= 1'b1;
							fired_q <= fired_q + ate_pkg::FIRE_W'(1);
						end else begin
							wr_q <= wr_q + ate_pkg::CNT_W'(1);
						end
					end else if (!issue) begin
						count_q <= wr_q;
						strobe  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pid_q <= item.process_id;
			tag_q <= item.alert_tag;
		end
		unique case (state_q)
			ST_IDLE: begin
				result.kind         <= ate_pkg::KIND_FULL;
				result.alert_pid    <= '0;
				result.alert_prefix <= '0;
				result.last         <= 1'b1;
			end
			ST_DIV: begin
				result.kind         <= ate_pkg::KIND_REG;
				result.alert_pid    <= '0;
				result.alert_prefix <= '0;
				result.last         <= 1'b1;
			end
			ST_SCAN: begin
				if (vld_s1) begin
					if (hit) begin
						result.kind         <= ate_pkg::KIND_FIRED;
						result.alert_pid    <= pend_pid_q;
						result.alert_prefix <= pend_prefix_q;
						result.last         <= 1'b0;
						pend_pid_q          <= rdata.pid;
						pend_prefix_q       <= rdata.prefix;
					end
				end else if (pend_q) begin
					result.kind         <= ate_pkg::KIND_FIRED;
					result.alert_pid    <= pend_pid_q;
					result.alert_prefix <= pend_prefix_q;
					result.last         <= 1'b1;
				end else begin
					result.kind         <= ate_pkg::KIND_NONE;
					result.alert_pid    <= '0;
					result.alert_prefix <= '0;
					result.last         <= 1'b1;
				end
			end
			default: begin
				result.kind <= ate_pkg::KIND_NONE;
			end
		endcase
	end

	`ASSERT_AR(a_count_bound, clk, arst_n, count_q <= ate_pkg::ENT_CNT)
	`ASSERT_AR(a_single_last, clk, arst_n, (strobe && result.kind != ate_pkg::KIND_FIRED) |-> result.last)
	`ASSERT_AR(a_tick_step, clk, arst_n, (accept && item.cmd == ate_pkg::CMD_TICK) |=> (tick_q == $past(tick_q) + 64'd1))
	`ASSERT_AR(a_wr_behind_rd, clk, arst_n, (state_q == ST_SCAN) |-> (wr_q <= rd_q))
	`ASSERT_CK(a_quiet_in_reset, clk, !arst_n |=> !strobe)
endmodule

// ----- tb/alarm_table_checker.sv -----
// Checker for the alarm table: predicts the answers to every accepted word and compares them.
module alarm_table_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  ate_pkg::in_word_t  item,
	input  logic               strobe,
	input  ate_pkg::out_word_t result,
	output int                 errors,
	output int                 pending,
	output int                 alerts,
	output int                 rejects
);
	logic [63:0]        tick_now;
	int                 stored;
	logic [15:0]        slot_pid [ate_pkg::ENTRIES];
	logic signed [7:0]  slot_tag [ate_pkg::ENTRIES];
	logic [63:0]        slot_due [ate_pkg::ENTRIES];
	ate_pkg::out_word_t answer_q [$];
	int                 err_cnt;
	int                 alert_cnt;
	int                 reject_cnt;

	function automatic ate_pkg::out_word_t answer(logic [1:0] kind, logic [15:0] pid,
			logic [7:0] tag, logic last);
		ate_pkg::out_word_t a;
		a.kind = kind;
		a.alert_pid = pid;
		a.alert_prefix = tag;
		a.last = last;
		return a;
	endfunction

	// Applies one accepted word to the table and queues the answers it causes.
	task automatic advance_table(ate_pkg::in_word_t w);
		int i;
		int keep;
		int fire_total;
		int fired;
		if (w.cmd == ate_pkg::CMD_REG) begin
			if (stored >= ate_pkg::ENTRIES) begin
				answer_q.push_back(answer(ate_pkg::KIND_FULL, '0, '0, 1'b1));
				reject_cnt++;
			end else begin
				for (i = stored; i > 0; i--) begin
					slot_pid[i] = slot_pid[i-1];
					slot_tag[i] = slot_tag[i-1];
					slot_due[i] = slot_due[i-1];
				end
				slot_pid[0] = w.process_id;
				slot_tag[0] = w.alert_tag;
				slot_due[0] = 64'(w.delay_ms) / 64'(ate_pkg::MS_PER_TICK) + tick_now;
				stored++;
				answer_q.push_back(answer(ate_pkg::KIND_REG, '0, '0, 1'b1));
			end
		end else begin
			tick_now = tick_now + 64'd1;
			// Count first so the final alert of the burst can carry the last flag.
			fire_total = 0;
			for (i = 0; i < stored; i++) begin
				if (fire_total < ate_pkg::MAX_RESULTS && slot_due[i] <= tick_now)
					fire_total++;
			end
			keep = 0;
			fired = 0;
			for (i = 0; i < stored; i++) begin
				if (fired < fire_total && slot_due[i] <= tick_now) begin
					answer_q.push_back(answer(ate_pkg::KIND_FIRED, slot_pid[i], slot_tag[i],
						fired == fire_total - 1));
					fired++;
				end else begin
					slot_pid[keep] = slot_pid[i];
					slot_tag[keep] = slot_tag[i];
					slot_due[keep] = slot_due[i];
					keep++;
				end
			end
			stored = keep;
			alert_cnt += fire_total;
			if (fire_total == 0)
				answer_q.push_back(answer(ate_pkg::KIND_NONE, '0, '0, 1'b1));
		end
	endtask

	task automatic compare_word(ate_pkg::out_word_t got);
		ate_pkg::out_word_t want;
		if (answer_q.size() == 0) begin
			$error("result word with no expectation waiting: kind %0d pid %0h", got.kind,
				got.alert_pid);
			err_cnt++;
		end else begin
			want = answer_q.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, actual %0d", want.kind, got.kind);
				err_cnt++;
			end
			if (got.alert_pid !== want.alert_pid) begin
				$error("alert_pid: expected %0h, actual %0h", want.alert_pid, got.alert_pid);
				err_cnt++;
			end
			if (got.alert_prefix !== want.alert_prefix) begin
				$error("alert_prefix: expected %0d, actual %0d", want.alert_prefix,
					got.alert_prefix);
				err_cnt++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, got.last);
				err_cnt++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_now = '0;
			stored = 0;
			answer_q.delete();
			err_cnt = 0;
			alert_cnt = 0;
			reject_cnt = 0;
			errors <= 0;
			pending <= 0;
			alerts <= 0;
			rejects <= 0;
		end else begin
			if (start === 1'b1 && busy === 1'b0)
				advance_table(item);
			if (strobe === 1'b1) begin
				compare_word(result);
			end else if (strobe !== 1'b0) begin
				$error("strobe: expected 0 or 1, actual %b", strobe);
				err_cnt++;
			end
			errors <= err_cnt;
			pending <= answer_q.size();
			alerts <= alert_cnt;
			rejects <= reject_cnt;
		end
	end
endmodule

// ----- tb/testbench.sv -----
// Top of the alarm table testbench: reset, stimulus, idling and the final verdict.
module testbench;
	localparam int LIMIT = 200000;
	localparam int RANDOM_WORDS = 136;
	localparam int DRAIN_CYCLES = 40;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               strobe;
	ate_pkg::in_word_t  item;
	ate_pkg::out_word_t result;
	int                 errors;
	int                 pending;
	int                 alerts;
	int                 rejects;
	int                 cycles = 0;
	int                 reg_sent = 0;
	int                 tick_sent = 0;
	int                 long_left = 3;
	bit                 steady = 1'b0;

	alarm_table_expiry dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	alarm_table_checker watch (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.strobe  (strobe),
		.result  (result),
		.errors  (errors),
		.pending (pending),
		.alerts  (alerts),
		.rejects (rejects)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("Run stopped after %0d cycles with %0d answers outstanding", cycles, pending);
			$display("Verification failed");
			$finish;
		end
	end

	function automatic ate_pkg::in_word_t reg_word(logic [15:0] pid, logic [7:0] tag,
			logic [31:0] delay);
		ate_pkg::in_word_t w;
		w.cmd = ate_pkg::CMD_REG;
		w.process_id = pid;
		w.alert_tag = tag;
		w.delay_ms = delay;
		return w;
	endfunction

	// The other fields of a tick word are ignored, so they carry noise.
	function automatic ate_pkg::in_word_t tick_word();
		ate_pkg::in_word_t w;
		w.cmd = ate_pkg::CMD_TICK;
		w.process_id = 16'($urandom);
		w.alert_tag = 8'($urandom);
		w.delay_ms = $urandom;
		return w;
	endfunction

	// Mostly delays of a few dozen ticks; a handful never expire within the run.
	function automatic logic [31:0] random_delay();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3 && long_left > 0) begin
			long_left--;
			return $urandom;
		end
		if (r < 12)
			return $urandom_range(0, 9);
		return $urandom_range(0, 400);
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// Presents one word and returns at the edge that takes it.
	task automatic send(ate_pkg::in_word_t w);
		start <= 1'b1;
		item <= w;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		if (w.cmd == ate_pkg::CMD_REG)
			reg_sent++;
		else
			tick_sent++;
	endtask

	task automatic idle(int n);
		ate_pkg::in_word_t junk;
		if (n > 0) begin
			junk = tick_word();
			junk.cmd = 1'($urandom_range(0, 1));
			start <= 1'b0;
			item <= junk;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_then_idle(ate_pkg::in_word_t w);
		send(w);
		idle(pick_gap());
	endtask

	initial begin
		int done;
		int seg_len;
		int reg_pct;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A tick on an empty table, then alarms at the edges of the fields.
		send_then_idle(tick_word());
		send_then_idle(reg_word(16'hFFFF, 8'h80, 32'hFFFF_FFFF));
		send_then_idle(reg_word(16'h0000, 8'h7F, 32'd0));
		send_then_idle(reg_word(16'h1234, 8'hFF, 32'd9));
		send_then_idle(reg_word(16'h8001, 8'h00, 32'd10));
		send_then_idle(reg_word(16'h00FF, 8'h01, 32'd20));
		// Fires three entries from the middle of the table, newest first.
		send_then_idle(tick_word());
		// Fill the table to the brim, then one word too many.
		repeat (14)
			send_then_idle(reg_word(16'($urandom), 8'($urandom), $urandom_range(0, 29)));
		send_then_idle(reg_word(16'($urandom), 8'($urandom), $urandom));
		// A large burst of expiries, then the stragglers.
		send_then_idle(tick_word());
		send_then_idle(tick_word());

		done = 0;
		while (done < RANDOM_WORDS) begin
			seg_len = $urandom_range(5, 20);
			case ($urandom_range(0, 2))
				0: reg_pct = 20;
				1: reg_pct = 50;
				default: reg_pct = 85;
			endcase
			steady = ($urandom_range(0, 3) == 0);
			repeat (seg_len) begin
				if ($urandom_range(0, 99) < reg_pct)
					send_then_idle(reg_word(16'($urandom), 8'($urandom), random_delay()));
				else
					send_then_idle(tick_word());
				done++;
			end
		end
		steady = 1'b0;
		start <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d register words, %0d of them refused on a full table,", reg_sent,
			rejects);
		$display("and %0d tick words that fired %0d alerts.", tick_sent, alerts);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
